@@ hw/rtl/ugas_pkg.sv @@
// Shared types and constants for the undirected graph adjacency store.
// Holds the fixed field widths, the request mode codes and the row memory control word.
// No dependencies.
`default_nettype none

package ugas_pkg;

  // Fixed widths of the port fields
  localparam int MODE_W = 2;
  localparam int VTX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int VCNT_W = 7;
  localparam int ECNT_W = 11;

  // Request mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT        = 2'd0,
    MODE_REMOVE_EDGE   = 2'd1,
    MODE_REMOVE_VERTEX = 2'd2,
    MODE_QUERY         = 2'd3
  } mode_t;

  // Control word from the sequencer to the row memory
  typedef struct packed {
    logic wr_en;    // write one row, marks it valid
    logic inv_en;   // mark one row invalid (reads as zero)
    logic clr_all;  // mark every row invalid
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/ugas_mem.sv @@
// Adjacency row memory: one write port, one registered read port,
// per-row valid bits so that a cleared row reads as zero.
// Depends on ugas_pkg (mem_ctl_t).
`default_nettype none

module ugas_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  ugas_pkg::mem_ctl_t           ctl,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire  [WIDTH-1:0]             wr_data,
  input  wire  [$clog2(DEPTH)-1:0]     inv_addr,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [WIDTH-1:0]             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  // Row storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits and registered read qualifier
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid[rd_addr] && !ctl.clr_all;
      if (ctl.clr_all) begin
        valid <= '0;
      end else begin
        if (ctl.wr_en) begin
          valid[wr_addr] <= 1'b1;
        end
        if (ctl.inv_en) begin
          valid[inv_addr] <= 1'b0;
        end
      end
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/undirected_graph_adjacency_store.sv @@
// Undirected graph adjacency store, top level. Keeps a simple undirected
// graph as a symmetric bit matrix, one row per vertex in a single-port-write,
// registered-read memory, plus vertex and edge counters. Every request word
// returns one result word. Out-of-range edge and vertex-removal requests go
// straight to the completion state, queries via the query state, edge
// insert/remove via the edge states (read row a, write row a while reading
// row b, write row b), or just the first when the edge is a duplicate,
// missing or a self-loop. Removing a vertex sweeps the rows once through the
// memory port, one row a cycle, compacting rows and columns. A new request is
// taken once the previous one has reached the output register; writing the size
// register zeroes the edge count and, when idle, clears all rows at once (no clearing pass).
// Depends on ugas_pkg and ugas_mem.
`default_nettype none

module undirected_graph_adjacency_store #(
  parameter int MAX_VERTICES = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration
  input  wire                                cfg_wr_en,
  input  wire  [ugas_pkg::CFG_W-1:0]         cfg_wr_data,
  // request channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [ugas_pkg::MODE_W-1:0]        mode,
  input  wire  [ugas_pkg::VTX_W-1:0]         vertex_a,
  input  wire  [ugas_pkg::VTX_W-1:0]         vertex_b,
  // result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               status,
  output logic                               adjacent,
  output logic [ugas_pkg::VCNT_W-1:0]        vertex_count,
  output logic [ugas_pkg::ECNT_W-1:0]        edge_count
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int EW   = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
  localparam int VW   = ugas_pkg::VTX_W;
  localparam int CMW  = (CW > VW) ? CW : VW;
  localparam int SW   = (CW > ugas_pkg::CFG_W) ? CW : ugas_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_SWEEP,
    S_QUERY,
    S_DONE
  } state_t;

  state_t                  state;
  ugas_pkg::mode_t         mode_q;
  logic [VW-1:0]           a_q;
  logic [VW-1:0]           b_q;
  logic [CW-1:0]           vtx_cnt;
  logic [EW-1:0]           edge_cnt;
  logic [CW-1:0]           rd_idx;
  logic                    pend_q;
  logic [AW-1:0]           dst_q;
  logic                    res_status;
  logic                    res_adj;

  ugas_pkg::mem_ctl_t      mem_ctl;
  logic [AW-1:0]           wr_addr;
  logic [MAX_VERTICES-1:0] wr_data;
  logic [AW-1:0]           inv_addr;
  logic [AW-1:0]           rd_addr;
  logic [MAX_VERTICES-1:0] rd_row;

  function automatic logic in_rng(input logic [VW-1:0] x, input logic [CW-1:0] n);
    return CMW'(x) < CMW'(n);
  endfunction

  ugas_mem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (MAX_VERTICES)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .inv_addr (inv_addr),
    .rd_addr  (rd_addr),
    .rd_data  (rd_row)
  );

  // Decode of the stored request against the row just read
  logic [AW-1:0]           a_idx;
  logic [AW-1:0]           b_idx;
  logic                    is_ins;
  logic                    hit;
  logic                    edge_apply;
  logic [MAX_VERTICES-1:0] bit_a;
  logic [MAX_VERTICES-1:0] bit_b;

  assign a_idx      = AW'(a_q);
  assign b_idx      = AW'(b_q);
  assign is_ins     = (mode_q == ugas_pkg::MODE_INSERT);
  assign hit        = rd_row[b_idx];
  assign edge_apply = is_ins ? ((a_q != b_q) && !hit) : hit;
  assign bit_a      = MAX_VERTICES'(1) << a_idx;
  assign bit_b      = MAX_VERTICES'(1) << b_idx;

  // Sweep indexing: destination row rd_idx takes source row rd_idx or rd_idx+1
  logic [CW-1:0]           last_idx;
  logic                    more;
  logic [CW-1:0]           src_idx;
  logic                    sweep_end;

  assign last_idx  = vtx_cnt - CW'(1);
  assign more      = rd_idx < last_idx;
  assign src_idx   = rd_idx + CW'(CMW'(rd_idx) >= CMW'(a_q));
  assign sweep_end = !more && !pend_q;

  // Column compaction: drop column a, shift higher columns down by one
  logic [MAX_VERTICES-1:0] low_mask;
  logic [MAX_VERTICES-1:0] compact_row;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      low_mask[i] = AW'(i) < a_idx;
    end
    compact_row = (rd_row & low_mask) | ((rd_row >> 1) & ~low_mask);
  end

  // Memory port steering
  always_comb begin
    mem_ctl  = '0;
    wr_addr  = a_idx;
    wr_data  = rd_row;
    inv_addr = last_idx[AW-1:0];
    rd_addr  = a_idx;
    unique case (state)
      S_IDLE: begin
        rd_addr         = AW'(vertex_a);
        mem_ctl.clr_all = cfg_wr_en;
      end
      S_EDGE_A: begin
        rd_addr = b_idx;
        if (edge_apply) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = a_idx;
          wr_data       = is_ins ? (rd_row | bit_b) : (rd_row & ~bit_b);
        end
      end
      S_EDGE_B: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = b_idx;
        wr_data       = is_ins ? (rd_row | bit_a) : (rd_row & ~bit_a);
      end
      S_SWEEP: begin
        rd_addr = sweep_end ? a_idx : src_idx[AW-1:0];
        if (pend_q) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = dst_q;
          wr_data       = compact_row;
        end
        mem_ctl.inv_en = sweep_end;
      end
      S_QUERY, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      vtx_cnt   <= '0;
      edge_cnt  <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= ugas_pkg::mode_t'(mode);
            a_q    <= vertex_a;
            b_q    <= vertex_b;
            res_adj <= 1'b0;
            unique case (ugas_pkg::mode_t'(mode))
              ugas_pkg::MODE_INSERT, ugas_pkg::MODE_REMOVE_EDGE: begin
                if (in_rng(vertex_a, vtx_cnt) && in_rng(vertex_b, vtx_cnt)) begin
                  state <= S_EDGE_A;
                end else begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end
              end
              ugas_pkg::MODE_REMOVE_VERTEX: begin
                if (in_rng(vertex_a, vtx_cnt)) begin
                  res_status <= 1'b0;
                  rd_idx     <= '0;
                  pend_q     <= 1'b0;
                  state      <= S_SWEEP;
                end else begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end
              end
              ugas_pkg::MODE_QUERY: begin
                res_status <= !(in_rng(vertex_a, vtx_cnt) && in_rng(vertex_b, vtx_cnt));
                state      <= S_QUERY;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_EDGE_A: begin
          res_status <= !edge_apply;
          res_adj    <= is_ins && (a_q != b_q);
          if (edge_apply) begin
            edge_cnt <= is_ins ? (edge_cnt + EW'(1)) : (edge_cnt - EW'(1));
            state    <= S_EDGE_B;
          end else begin
            state <= S_DONE;
          end
        end
        S_EDGE_B: begin
          state <= S_DONE;
        end
        S_SWEEP: begin
          // each swept row with bit a set loses one edge
          if (pend_q && rd_row[a_idx]) begin
            edge_cnt <= edge_cnt - EW'(1);
          end
          if (more) begin
            pend_q <= 1'b1;
            dst_q  <= rd_idx[AW-1:0];
            rd_idx <= rd_idx + CW'(1);
          end else begin
            pend_q <= 1'b0;
          end
          if (sweep_end) begin
            vtx_cnt <= last_idx;
            state   <= S_QUERY;
          end
        end
        S_QUERY: begin
          res_adj <= in_rng(a_q, vtx_cnt) && in_rng(b_q, vtx_cnt) && hit;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            adjacent     <= res_adj;
            vertex_count <= ugas_pkg::VCNT_W'(vtx_cnt);
            edge_count   <= ugas_pkg::ECNT_W'(edge_cnt);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // size register write: sets the vertex count (saturating) and zeroes the edge count
      if (cfg_wr_en) begin
        edge_cnt <= '0;
        if (SW'(cfg_wr_data) > SW'(MAX_VERTICES)) begin
          vtx_cnt <= CW'(MAX_VERTICES);
        end else begin
          vtx_cnt <= CW'(cfg_wr_data);
        end
      end
    end
  end

  // Sweep never overwrites the row it is about to read
  a_sweep_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && mem_ctl.wr_en |-> wr_addr != rd_addr)
    else $error("sweep write hits the row being read");

  // A size write leaves the edge count at zero
  a_cfg_clears_edges: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> edge_cnt == '0)
    else $error("edge count not cleared by size write");

  // Vertex count stays within the storage
  a_vtx_bound: assert property (@(posedge clk) disable iff (rst)
    vtx_cnt <= CW'(MAX_VERTICES))
    else $error("vertex count above capacity");

  // A result only appears from the completion state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside completion");

endmodule

`default_nettype wire

@@ tb/undirected_graph_adjacency_store_test.sv @@
// Self-checking bench for undirected_graph_adjacency_store: directed then random
// graph requests, each result checked against a bit-matrix graph kept here.
// Depends on ugas_pkg and the undirected_graph_adjacency_store RTL.
module undirected_graph_adjacency_store_test;

  localparam int NV = 64;
  localparam logic [ugas_pkg::MODE_W-1:0] OP_INSERT        = ugas_pkg::MODE_INSERT;
  localparam logic [ugas_pkg::MODE_W-1:0] OP_REMOVE_EDGE   = ugas_pkg::MODE_REMOVE_EDGE;
  localparam logic [ugas_pkg::MODE_W-1:0] OP_REMOVE_VERTEX = ugas_pkg::MODE_REMOVE_VERTEX;
  localparam logic [ugas_pkg::MODE_W-1:0] OP_QUERY         = ugas_pkg::MODE_QUERY;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 75;

  typedef struct packed {
    logic [ugas_pkg::MODE_W-1:0] mode;
    logic [ugas_pkg::VTX_W-1:0]  a;
    logic [ugas_pkg::VTX_W-1:0]  b;
  } request_t;

  typedef struct packed {
    logic                        status;
    logic                        adjacent;
    logic [ugas_pkg::VCNT_W-1:0] vertices;
    logic [ugas_pkg::ECNT_W-1:0] edges;
  } graph_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [ugas_pkg::CFG_W-1:0]  cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  wire                         in_ready;
  logic [ugas_pkg::MODE_W-1:0] mode = '0;
  logic [ugas_pkg::VTX_W-1:0]  vertex_a = '0;
  logic [ugas_pkg::VTX_W-1:0]  vertex_b = '0;
  wire                         out_valid;
  logic                        out_ready = 1'b0;
  wire                         status;
  wire                         adjacent;
  wire [ugas_pkg::VCNT_W-1:0]  vertex_count;
  wire [ugas_pkg::ECNT_W-1:0]  edge_count;

  // graph as seen by the checker, updated on every accepted word
  logic [NV-1:0]   graph_rows [NV];
  int              graph_vertices = 0;
  int              graph_edges = 0;

  request_t        request_backlog [$];
  graph_result_t   awaited_results [$];
  int              gen_vertices = 0;     // vertex count the generator expects
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  bit              hold_request = 1'b0;
  bit              holding_off = 1'b0;
  int              taken_count = 0;      // words accepted, counted by the monitor
  int              offered_count = 0;    // words presented, counted by the driver
  int              mismatch_count = 0;

  undirected_graph_adjacency_store #(.MAX_VERTICES(NV)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .adjacent     (adjacent),
    .vertex_count (vertex_count),
    .edge_count   (edge_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got %0d want %0d", $time, what, got, want);
  endtask

  // Apply one request to the checker's graph and return the result it implies
  function automatic graph_result_t predict_request(request_t req);
    graph_result_t res;
    int a, b, n, i, r, c;
    bit both_in;
    a = req.a;
    b = req.b;
    n = graph_vertices;
    both_in = (a < n) && (b < n);
    res.status = 1'b1;
    case (req.mode)
      OP_INSERT: begin
        if (both_in && a != b && !graph_rows[a][b]) begin
          graph_rows[a][b] = 1'b1;
          graph_rows[b][a] = 1'b1;
          graph_edges++;
          res.status = 1'b0;
        end
      end
      OP_REMOVE_EDGE: begin
        if (both_in && graph_rows[a][b]) begin
          graph_rows[a][b] = 1'b0;
          graph_rows[b][a] = 1'b0;
          graph_edges--;
          res.status = 1'b0;
        end
      end
      OP_REMOVE_VERTEX: begin
        if (a < n) begin
          // drop the vertex's edges, then shift rows and columns down by one
          for (i = 0; i < n; i++) begin
            if (graph_rows[a][i]) begin
              graph_rows[a][i] = 1'b0;
              graph_rows[i][a] = 1'b0;
              graph_edges--;
            end
          end
          for (r = a; r + 1 < n; r++) graph_rows[r] = graph_rows[r + 1];
          graph_rows[n - 1] = '0;
          for (r = 0; r + 1 < n; r++) begin
            for (c = a; c + 1 < n; c++) graph_rows[r][c] = graph_rows[r][c + 1];
            graph_rows[r][n - 1] = 1'b0;
          end
          graph_vertices = n - 1;
          res.status = 1'b0;
        end
      end
      default: begin
        if (both_in) res.status = 1'b0;
      end
    endcase
    // adjacency uses the numbering after the step
    res.adjacent = (a < graph_vertices && b < graph_vertices) ? graph_rows[a][b] : 1'b0;
    res.vertices = ugas_pkg::VCNT_W'(graph_vertices);
    res.edges    = ugas_pkg::ECNT_W'(graph_edges);
    return res;
  endfunction

  // Monitor: check results, track size writes, predict accepted requests
  always @(posedge clk) begin : monitor
    graph_result_t want;
    request_t seen;
    if (rst) begin
      foreach (graph_rows[k]) graph_rows[k] = '0;
      graph_vertices = 0;
      graph_edges = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result word", 16'd1, 16'd0);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status)
            flag_mismatch("status", 16'(status), 16'(want.status));
          if (adjacent !== want.adjacent)
            flag_mismatch("adjacent", 16'(adjacent), 16'(want.adjacent));
          if (vertex_count !== want.vertices)
            flag_mismatch("vertex_count", 16'(vertex_count), 16'(want.vertices));
          if (edge_count !== want.edges)
            flag_mismatch("edge_count", 16'(edge_count), 16'(want.edges));
        end
      end
      if (cfg_wr_en) begin
        foreach (graph_rows[k]) graph_rows[k] = '0;
        graph_vertices = (cfg_wr_data > NV) ? NV : int'(cfg_wr_data);
        graph_edges = 0;
      end
      if (in_valid && in_ready) begin
        seen.mode = mode;
        seen.a    = vertex_a;
        seen.b    = vertex_b;
        awaited_results.push_back(predict_request(seen));
        taken_count++;
      end
    end
  end

  // Driver: present the next request word, hold it until taken
  always @(negedge clk) begin : driver
    request_t next_req;
    if (!rst && (taken_count == offered_count)) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = request_backlog.pop_front();
        in_valid <= 1'b1;
        mode     <= next_req.mode;
        vertex_a <= next_req.a;
        vertex_b <= next_req.b;
        offered_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= !holding_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps running
  initial begin
    wait (hold_request);
    holding_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    holding_off = 1'b0;
  end

  task automatic offer(logic [ugas_pkg::MODE_W-1:0] m, int a, int b);
    request_t req;
    req.mode = m;
    req.a    = ugas_pkg::VTX_W'(a);
    req.b    = ugas_pkg::VTX_W'(b);
    request_backlog.push_back(req);
  endtask

  // Wait until every request is taken and every result has come back
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (request_backlog.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(int value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ugas_pkg::CFG_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    gen_vertices = (value > NV) ? NV : value;
  endtask

  // Mostly in-range edge traffic, with some noise and vertex removals
  function automatic request_t random_request();
    request_t req;
    int pick;
    pick = $urandom_range(99);
    req.mode = ugas_pkg::MODE_W'($urandom_range(3));
    req.a    = ugas_pkg::VTX_W'($urandom_range(63));
    req.b    = ugas_pkg::VTX_W'($urandom_range(63));
    if (gen_vertices > 0 && pick >= 10) begin
      req.a = ugas_pkg::VTX_W'($urandom_range(gen_vertices - 1));
      req.b = ugas_pkg::VTX_W'($urandom_range(gen_vertices - 1));
      if (pick < 48) req.mode = OP_INSERT;
      else if (pick < 72) req.mode = OP_REMOVE_EDGE;
      else if (pick < 95) req.mode = OP_QUERY;
      else req.mode = OP_REMOVE_VERTEX;
    end
    if (req.mode == OP_REMOVE_VERTEX && req.a < gen_vertices) gen_vertices--;
    return req;
  endfunction

  initial begin : stimulus
    int size_plan [12] = '{8, 64, 3, 127, 16, 0, 6, 64, 2, 10, 5, 32};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty graph after reset: everything is out of range
    offer(OP_QUERY, 0, 0);
    offer(OP_REMOVE_VERTEX, 0, 0);
    settle();

    // small graph: duplicates, self-loop, missing edge, renumbering
    write_size(4);
    offer(OP_INSERT, 0, 1);
    offer(OP_INSERT, 0, 1);
    offer(OP_INSERT, 1, 0);
    offer(OP_INSERT, 2, 2);
    offer(OP_INSERT, 0, 63);
    offer(OP_INSERT, 3, 2);
    offer(OP_INSERT, 1, 3);
    offer(OP_QUERY, 0, 1);
    offer(OP_QUERY, 0, 2);
    offer(OP_REMOVE_EDGE, 0, 2);
    offer(OP_REMOVE_EDGE, 1, 0);
    offer(OP_REMOVE_VERTEX, 1, 2);
    offer(OP_QUERY, 1, 2);
    offer(OP_REMOVE_VERTEX, 63, 0);
    offer(OP_REMOVE_VERTEX, 2, 0);
    offer(OP_QUERY, 63, 63);
    settle();

    // oversized size value saturates; top vertex indices
    write_size(127);
    offer(OP_INSERT, 63, 62);
    offer(OP_INSERT, 0, 63);
    offer(OP_REMOVE_VERTEX, 0, 63);
    offer(OP_QUERY, 62, 61);
    offer(OP_REMOVE_EDGE, 61, 62);
    settle();

    // random phases, cycling through idle profiles
    foreach (size_plan[p]) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      write_size(size_plan[p]);
      if (p == 4) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) request_backlog.push_back(random_request());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
